/* sv/cht_pkg.sv */
package cht_pkg;

    localparam logic [1:0] KIND_ATTR  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_OK    = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_out_t;

endpackage

/* sv/cht_core.sv */
module cht_core #(
    parameter int PAIR_LIMIT = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          byte_in,
    input  logic                end_of_header,
    output cht_pkg::step_out_t  results
);

    typedef enum logic [2:0] {
        PH_START,
        PH_ATTR,
        PH_VLEAD,
        PH_VALUE,
        PH_DRAIN
    } phase_t;

    localparam logic [8:0] LIMIT = 9'(PAIR_LIMIT);

    phase_t     phase_reg, phase_next;
    logic       quote_reg, quote_next;
    logic [7:0] len_reg, len_next;
    logic       aseen_reg, aseen_next;

    function automatic cht_pkg::step_out_t push(cht_pkg::step_out_t s, logic [1:0] k,
                                                logic [7:0] d, logic l);
        cht_pkg::step_out_t o;
        o = s;
        if (s.count == 2'd0)
        begin
            o.r0 = '{kind: k, data: d, last: l};
        end
        else
        begin
            o.r1 = '{kind: k, data: d, last: l};
        end
        o.count = s.count + 2'd1;
        return o;
    endfunction

    always_comb
    begin
        phase_t             ph;
        logic               q;
        logic [7:0]         len;
        logic               aseen;
        logic               fail;
        logic               new_pair;
        cht_pkg::step_out_t o;

        ph       = phase_reg;
        q        = quote_reg;
        len      = len_reg;
        aseen    = aseen_reg;
        fail     = 1'b0;
        new_pair = 1'b0;
        o        = '0;

        if (phase_reg == PH_DRAIN)
        begin
            new_pair = end_of_header;
        end
        else if (phase_reg == PH_START && byte_in == cht_pkg::CH_SPACE)
        begin
            fail = end_of_header;
        end
        else
        begin
            if (ph == PH_START)
            begin
                ph = PH_ATTR;
            end
            if (byte_in == cht_pkg::CH_SEMI && !q)
            begin
                if (!aseen || ph == PH_VLEAD)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    o        = push(o, cht_pkg::KIND_OK, 8'd0, 1'b0);
                    new_pair = 1'b1;
                    fail     = end_of_header;
                end
            end
            else if ({1'b0, len} + 9'd1 >= LIMIT)
            begin
                fail = 1'b1;
            end
            else
            begin
                len = len + 8'd1;
                if (ph == PH_ATTR)
                begin
                    if (byte_in == cht_pkg::CH_QUOTE)
                    begin
                        q = !q;
                    end
                    else if (byte_in == cht_pkg::CH_EQ && !q)
                    begin
                        ph = PH_VLEAD;
                    end
                    else
                    begin
                        o     = push(o, cht_pkg::KIND_ATTR, byte_in, 1'b0);
                        aseen = 1'b1;
                    end
                end
                else
                begin
                    if (ph == PH_VLEAD && byte_in != cht_pkg::CH_SPACE)
                    begin
                        ph = PH_VALUE;
                    end
                    if (ph == PH_VALUE)
                    begin
                        if (byte_in == cht_pkg::CH_QUOTE)
                        begin
                            q = !q;
                        end
                        o = push(o, cht_pkg::KIND_VALUE, byte_in, 1'b0);
                    end
                end
                if (end_of_header)
                begin
                    if (!aseen || ph == PH_VLEAD)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        o        = push(o, cht_pkg::KIND_OK, 8'd0, 1'b1);
                        new_pair = 1'b1;
                    end
                end
            end
        end

        if (fail)
        begin
            o = push(o, cht_pkg::KIND_ERR, 8'd0, 1'b1);
        end

        if (fail || new_pair)
        begin
            phase_next = (fail && !end_of_header) ? PH_DRAIN : PH_START;
            quote_next = 1'b0;
            len_next   = 8'd0;
            aseen_next = 1'b0;
        end
        else
        begin
            phase_next = ph;
            quote_next = q;
            len_next   = len;
            aseen_next = aseen;
        end

        results = o;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            quote_reg <= 1'b0;
            len_reg   <= 8'd0;
            aseen_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            quote_reg <= quote_next;
            len_reg   <= len_next;
            aseen_reg <= aseen_next;
        end
    end

endmodule

/* sv/cookie_header_tokenizer.sv */
// A byte is registered in the input register; its results are written into the result queue when
// the byte advances, which waits for queue space, and are shown from the head of the queue.
// Throughput: one byte per cycle while each byte gives at most one result and the receiver does
// not stall; a byte giving two results drains one at a time through the four-entry result queue.
// Reset clears the parser state to pair start and empties the input register and the queue.
module cookie_header_tokenizer #(
    parameter int PAIR_LIMIT = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    input  logic       end_of_header,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] data_byte,
    output logic       last
);

    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    logic                hold_valid_reg, hold_valid_next;
    logic [7:0]          hold_byte_reg;
    logic                hold_eoh_reg;
    logic                accept_in;
    logic                advance;
    logic                pop;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    count_after_pop;
    logic [PTR_W-1:0]    rd_ptr_reg, wr_ptr_reg;
    cht_pkg::result_t    queue_reg [QDEPTH];
    cht_pkg::step_out_t  results;
    cht_pkg::result_t    head;

    cht_core #(
        .PAIR_LIMIT(PAIR_LIMIT)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .byte_in      (hold_byte_reg),
        .end_of_header(hold_eoh_reg),
        .results      (results)
    );

    assign out_valid       = (count_reg != '0);
    assign pop             = out_valid && !out_stall;
    assign count_after_pop = count_reg - CNT_W'(pop);
    assign advance         = hold_valid_reg && (count_after_pop <= CNT_W'(QDEPTH - 2));
    assign in_stall        = hold_valid_reg && !advance;
    assign accept_in       = in_valid && !in_stall;
    assign hold_valid_next = accept_in ? 1'b1 : (advance ? 1'b0 : hold_valid_reg);
    assign count_next      = count_after_pop + (advance ? CNT_W'(results.count) : '0);

    assign head      = queue_reg[rd_ptr_reg];
    assign kind      = head.kind;
    assign data_byte = head.data;
    assign last      = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            count_reg      <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            count_reg      <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (advance)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(results.count);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            hold_byte_reg <= byte_in;
            hold_eoh_reg  <= end_of_header;
        end
        if (advance && results.count != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= results.r0;
        end
        if (advance && results.count == 2'd2)
        begin
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= results.r1;
        end
    end

    // The queue never holds more entries than it has.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(QDEPTH))
        else $error("result queue overflow");

    // Character results never close a header.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == cht_pkg::KIND_ATTR || kind == cht_pkg::KIND_VALUE) |-> !last)
        else $error("character result marked last");

    // Accept and error results carry no character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == cht_pkg::KIND_OK || kind == cht_pkg::KIND_ERR)
        |-> data_byte == 8'd0)
        else $error("status result carries data");

    // A byte leaves the input register only when the queue can take all its results.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> count_after_pop + CNT_W'(results.count) <= CNT_W'(QDEPTH))
        else $error("queue space check failed");

endmodule

/* tb/cookie_header_tokenizer_checker.sv */
`timescale 1ns / 100ps

module cookie_header_tokenizer_checker #(
    parameter int PAIR_LIMIT = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] byte_in,
    input  logic       end_of_header,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [1:0] kind,
    input  logic [7:0] data_byte,
    input  logic       last,
    output int         failures,
    output int         pending
);

    typedef enum logic [2:0] {
        AT_PAIR_START,
        IN_ATTRIBUTE,
        SKIP_VALUE_SPACES,
        IN_VALUE,
        DRAINING
    } scan_phase_t;

    scan_phase_t       phase;
    logic              in_quotes;
    int                pair_len;
    logic              attr_seen;
    cht_pkg::result_t  expected_tokens[$];
    int                mismatches = 0;
    int                token_count = 0;

    function automatic bit pair_complete();
        return attr_seen && (phase != SKIP_VALUE_SPACES);
    endfunction

    task automatic open_pair();
        phase = AT_PAIR_START;
        in_quotes = 1'b0;
        pair_len = 0;
        attr_seen = 1'b0;
    endtask

    task automatic emit(input logic [1:0] k, input logic [7:0] d, input logic l);
        cht_pkg::result_t r;
        r.kind = k;
        r.data = d;
        r.last = l;
        expected_tokens.push_back(r);
    endtask

    task automatic header_error(input logic eoh);
        emit(cht_pkg::KIND_ERR, 8'h00, 1'b1);
        open_pair();
        if (!eoh)
        begin
            phase = DRAINING;
        end
    endtask

    task automatic tokenize_byte(input logic [7:0] b, input logic eoh);
        if (phase == DRAINING)
        begin
            if (eoh)
            begin
                open_pair();
            end
            return;
        end
        if (phase == AT_PAIR_START)
        begin
            if (b == cht_pkg::CH_SPACE)
            begin
                if (eoh)
                begin
                    header_error(eoh);
                end
                return;
            end
            phase = IN_ATTRIBUTE;
        end
        if (b == cht_pkg::CH_SEMI && !in_quotes)
        begin
            if (!pair_complete())
            begin
                header_error(eoh);
                return;
            end
            emit(cht_pkg::KIND_OK, 8'h00, 1'b0);
            if (eoh)
            begin
                header_error(eoh);
            end
            else
            begin
                open_pair();
            end
            return;
        end
        if (pair_len + 1 >= PAIR_LIMIT)
        begin
            header_error(eoh);
            return;
        end
        pair_len++;
        if (phase == IN_ATTRIBUTE)
        begin
            if (b == cht_pkg::CH_QUOTE)
            begin
                in_quotes = !in_quotes;
            end
            else if (b == cht_pkg::CH_EQ && !in_quotes)
            begin
                phase = SKIP_VALUE_SPACES;
            end
            else
            begin
                emit(cht_pkg::KIND_ATTR, b, 1'b0);
                attr_seen = 1'b1;
            end
        end
        else
        begin
            if (phase == SKIP_VALUE_SPACES && b != cht_pkg::CH_SPACE)
            begin
                phase = IN_VALUE;
            end
            if (phase == IN_VALUE)
            begin
                if (b == cht_pkg::CH_QUOTE)
                begin
                    in_quotes = !in_quotes;
                end
                emit(cht_pkg::KIND_VALUE, b, 1'b0);
            end
        end
        if (eoh)
        begin
            if (!pair_complete())
            begin
                header_error(eoh);
                return;
            end
            emit(cht_pkg::KIND_OK, 8'h00, 1'b1);
            open_pair();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR: result %0d: %s: got 0x%0h, expected 0x%0h",
                 token_count, what, got, want);
        mismatches++;
    endtask

    task automatic check_token(input logic [1:0] k, input logic [7:0] d, input logic l);
        cht_pkg::result_t want;
        if (expected_tokens.size() == 0)
        begin
            report_mismatch("result with none expected", int'(k), 0);
        end
        else
        begin
            want = expected_tokens.pop_front();
            if (k !== want.kind)
            begin
                report_mismatch("kind", int'(k), int'(want.kind));
            end
            if (d !== want.data)
            begin
                report_mismatch("data_byte", int'(d), int'(want.data));
            end
            if (l !== want.last)
            begin
                report_mismatch("last", int'(l), int'(want.last));
            end
        end
        token_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_pair();
            expected_tokens.delete();
            failures <= 0;
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                tokenize_byte(byte_in, end_of_header);
            end
            if (out_valid && !out_stall)
            begin
                check_token(kind, data_byte, last);
            end
            failures <= mismatches;
            pending <= expected_tokens.size();
        end
    end

endmodule

/* tb/cookie_header_tokenizer_tb.sv */
`timescale 1ns / 100ps

module cookie_header_tokenizer_tb;

    localparam int PAIR_LIMIT = 128;
    localparam int RANDOM_ITEMS = 600;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] byte_in = 8'h00;
    logic       end_of_header = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;

    int         failures;
    int         pending;
    int         cycle_count = 0;
    int         sent = 0;
    logic [7:0] header_bytes[$];

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    cookie_header_tokenizer #(
        .PAIR_LIMIT(PAIR_LIMIT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .byte_in(byte_in),
        .end_of_header(end_of_header),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .data_byte(data_byte),
        .last(last)
    );

    cookie_header_tokenizer_checker #(
        .PAIR_LIMIT(PAIR_LIMIT)
    ) checker_inst (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .byte_in(byte_in),
        .end_of_header(end_of_header),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .data_byte(data_byte),
        .last(last),
        .failures(failures),
        .pending(pending)
    );

    // The receiver stops for a long stretch so that the block backs up and stalls its input.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= 400 && cycle_count < 480)
        begin
            out_stall <= 1'b1;
        end
        else if (cycle_count >= 150 && cycle_count < 330)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < 14);
        end
    end

    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic eoh);
        bit taken;
        while (!(sent >= 200 && sent < 320) && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in <= b;
        end_of_header <= eoh;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], close && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] value_byte();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(1, 255));
        end
        while (c == cht_pkg::CH_SEMI || c == cht_pkg::CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] attr_byte();
        logic [7:0] c;
        if ($urandom_range(99) < 80)
        begin
            return 8'($urandom_range(8'h61, 8'h7A));
        end
        do
        begin
            c = 8'($urandom_range(1, 255));
        end
        while (c == cht_pkg::CH_SEMI || c == cht_pkg::CH_QUOTE || c == cht_pkg::CH_EQ);
        return c;
    endfunction

    task automatic build_pair();
        int  alen;
        int  vlen;
        bit  long_pair;
        if ($urandom_range(99) < 25)
        begin
            repeat ($urandom_range(1, 2)) header_bytes.push_back(cht_pkg::CH_SPACE);
        end
        long_pair = ($urandom_range(99) < 4);
        alen = $urandom_range(1, 6);
        if ($urandom_range(99) < 10)
        begin
            header_bytes.push_back(cht_pkg::CH_QUOTE);
            repeat (alen)
            begin
                header_bytes.push_back(($urandom_range(99) < 20) ? cht_pkg::CH_SEMI : attr_byte());
            end
            header_bytes.push_back(cht_pkg::CH_QUOTE);
        end
        else
        begin
            repeat (alen) header_bytes.push_back(attr_byte());
        end
        if ($urandom_range(99) < 10)
        begin
            return;
        end
        header_bytes.push_back(cht_pkg::CH_EQ);
        if ($urandom_range(99) < 20)
        begin
            repeat ($urandom_range(1, 2)) header_bytes.push_back(cht_pkg::CH_SPACE);
        end
        if (long_pair)
        begin
            vlen = $urandom_range(118, 140);
        end
        else
        begin
            vlen = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 8);
        end
        if ($urandom_range(99) < 10)
        begin
            header_bytes.push_back(cht_pkg::CH_QUOTE);
            repeat (vlen)
            begin
                header_bytes.push_back(($urandom_range(99) < 20) ? cht_pkg::CH_SEMI : value_byte());
            end
            header_bytes.push_back(cht_pkg::CH_QUOTE);
        end
        else
        begin
            repeat (vlen) header_bytes.push_back(value_byte());
        end
    endtask

    task automatic send_header();
        int npairs;
        header_bytes.delete();
        npairs = $urandom_range(1, 4);
        for (int p = 0; p < npairs; p++)
        begin
            if (p > 0)
            begin
                header_bytes.push_back(cht_pkg::CH_SEMI);
            end
            build_pair();
        end
        if ($urandom_range(99) < 5)
        begin
            header_bytes.push_back(cht_pkg::CH_SEMI);
        end
        if ($urandom_range(99) < 6)
        begin
            header_bytes.insert($urandom_range(0, header_bytes.size() - 1), cht_pkg::CH_SEMI);
        end
        if ($urandom_range(99) < 8)
        begin
            header_bytes[$urandom_range(0, header_bytes.size() - 1)] = any_byte();
        end
        for (int i = 0; i < header_bytes.size(); i++)
        begin
            send_byte(header_bytes[i], i == header_bytes.size() - 1);
        end
    endtask

    initial
    begin
        int directed_count;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("a=b;", 1'b1);
        send_text(";", 1'b1);
        send_text("\"\"=x", 1'b1);
        send_text("=v;k", 1'b1);
        send_text(" k= ", 1'b1);
        send_text("\"a;b\"", 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(cht_pkg::CH_EQ, 1'b0);
        send_byte(8'hFF, 1'b1);
        directed_count = sent;

        while (sent < directed_count + RANDOM_ITEMS)
        begin
            send_header();
        end

        in_valid <= 1'b0;
        end_of_header <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (failures == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* files.f */
sv/cht_pkg.sv
sv/cht_core.sv
sv/cookie_header_tokenizer.sv
tb/cookie_header_tokenizer_checker.sv
tb/cookie_header_tokenizer_tb.sv
